FILE: hdl/suis_pkg.sv
// Shared types and constants for the sorted unique index set.
package suis_pkg;

   // Default number of entries in the value store
   localparam int CAPACITY_DEF = 32;

   // Fixed field widths of the item and result channels
   localparam int VALUE_W = 31;
   localparam int POS_W   = 5;
   localparam int DCNT_W  = 6;

   // Sequencer states
   typedef enum logic [2:0] {
      S_LOAD,
      S_SCAN,
      S_EMIT_RD,
      S_EMIT_LD,
      S_EMIT_WAIT
   } state_type;

endpackage

FILE: hdl/suis_if.sv
// Channel interfaces: input item channel and result channel.
interface suis_req_if;
   logic                         valid;
   logic                         ready;
   logic [suis_pkg::VALUE_W-1:0] value;
   logic                         set_end;

   modport source (output valid, output value, output set_end, input ready);
   modport sink   (input valid, input value, input set_end, output ready);
endinterface

interface suis_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [suis_pkg::VALUE_W-1:0] value_res;
   logic [suis_pkg::POS_W-1:0]   position;
   logic [suis_pkg::DCNT_W-1:0]  distinct_count;
   logic                         run_last;
   logic                         overflowed;

   modport source (output valid, output value_res, output position,
                   output distinct_count, output run_last, output overflowed,
                   input ready);
   modport sink   (input valid, input value_res, input position,
                   input distinct_count, input run_last, input overflowed,
                   output ready);
endinterface

FILE: hdl/suis_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module suis_ram #(
   parameter int DEPTH = suis_pkg::CAPACITY_DEF,
   parameter int WIDTH = suis_pkg::VALUE_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/suis_seq.sv
// Sequencer: loads items into the store, finds distinct values in ascending
// order by repeated scans, and emits them from the distinct-value memory.
module suis_seq #(
   parameter int CAPACITY = suis_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   suis_req_if.sink                             req_ch,
   suis_rsp_if.source                           rsp_ch,
   // entry store ports
   output logic                                 ent_wr_en,
   output logic [$clog2(CAPACITY)-1:0]          ent_wr_addr,
   output logic [suis_pkg::VALUE_W-1:0]         ent_wr_data,
   output logic                                 ent_rd_en,
   output logic [$clog2(CAPACITY)-1:0]          ent_rd_addr,
   input  logic [suis_pkg::VALUE_W-1:0]         ent_rd_data,
   // distinct-value memory ports
   output logic                                 dst_wr_en,
   output logic [$clog2(CAPACITY)-1:0]          dst_wr_addr,
   output logic [suis_pkg::VALUE_W-1:0]         dst_wr_data,
   output logic                                 dst_rd_en,
   output logic [$clog2(CAPACITY)-1:0]          dst_rd_addr,
   input  logic [suis_pkg::VALUE_W-1:0]         dst_rd_data,
   output suis_pkg::state_type                  state
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int VW = suis_pkg::VALUE_W;

   suis_pkg::state_type state_ff, state_in;

   logic [CW-1:0] count_ff,  count_in;    // entries stored
   logic          ovf_ff,    ovf_in;      // a value was dropped
   logic [CW-1:0] rd_idx_ff, rd_idx_in;   // scan read index
   logic          rd_vld_ff, rd_vld_in;   // read data arrives this cycle
   logic          rd_last_ff, rd_last_in; // arriving data ends the pass
   logic [VW-1:0] best_ff,   best_in;     // smallest candidate so far
   logic          best_vld_ff, best_vld_in;
   logic [VW-1:0] prev_ff,   prev_in;     // last distinct value found
   logic          prev_vld_ff, prev_vld_in;
   logic [CW-1:0] dcnt_ff,   dcnt_in;     // distinct values found
   logic [CW-1:0] emit_ff,   emit_in;     // emission index
   logic          rsp_vld_ff, rsp_vld_in;
   logic [VW-1:0] val_ff,    val_in;
   logic [suis_pkg::POS_W-1:0] pos_ff, pos_in;
   logic          last_ff,   last_in;

   logic          qual;
   logic          take;
   logic [VW-1:0] nbest;
   logic          nbest_vld;
   logic [CW-1:0] emit_nx;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= suis_pkg::S_LOAD;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         rd_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         rd_vld_ff   <= rd_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      rd_last_ff  <= rd_last_in;
      best_ff     <= best_in;
      best_vld_ff <= best_vld_in;
      prev_ff     <= prev_in;
      prev_vld_ff <= prev_vld_in;
      dcnt_ff     <= dcnt_in;
      emit_ff     <= emit_in;
      val_ff      <= val_in;
      pos_ff      <= pos_in;
      last_ff     <= last_in;
   end

   assign emit_nx = emit_ff + CW'(1);

   // Candidate compare for the scan pass: smallest value above the previous one
   assign qual      = !prev_vld_ff || (ent_rd_data > prev_ff);
   assign take      = qual && (!best_vld_ff || (ent_rd_data < best_ff));
   assign nbest     = take ? ent_rd_data : best_ff;
   assign nbest_vld = best_vld_ff || take;

   // Next state and memory control
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      rd_idx_in   = rd_idx_ff;
      rd_vld_in   = 1'b0;
      rd_last_in  = rd_last_ff;
      best_in     = best_ff;
      best_vld_in = best_vld_ff;
      prev_in     = prev_ff;
      prev_vld_in = prev_vld_ff;
      dcnt_in     = dcnt_ff;
      emit_in     = emit_ff;
      rsp_vld_in  = rsp_vld_ff;
      val_in      = val_ff;
      pos_in      = pos_ff;
      last_in     = last_ff;

      req_ch.ready = 1'b0;
      ent_wr_en    = 1'b0;
      ent_wr_addr  = count_ff[AW-1:0];
      ent_wr_data  = req_ch.value;
      ent_rd_en    = 1'b0;
      ent_rd_addr  = rd_idx_ff[AW-1:0];
      dst_wr_en    = 1'b0;
      dst_wr_addr  = dcnt_ff[AW-1:0];
      dst_wr_data  = nbest;
      dst_rd_en    = 1'b0;
      dst_rd_addr  = emit_ff[AW-1:0];

      case (state_ff)
         // Store items one per cycle; drop and flag once full
         suis_pkg::S_LOAD: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               if (count_ff != CW'(CAPACITY)) begin
                  ent_wr_en = 1'b1;
                  count_in  = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_ch.set_end) begin
                  state_in    = suis_pkg::S_SCAN;
                  rd_idx_in   = '0;
                  best_vld_in = 1'b0;
                  prev_vld_in = 1'b0;
                  dcnt_in     = '0;
               end
            end
         end

         // One pass over the store per distinct value, plus a final pass that finds none
         suis_pkg::S_SCAN: begin
            if (rd_idx_ff < count_ff) begin
               ent_rd_en  = 1'b1;
               rd_idx_in  = rd_idx_ff + CW'(1);
               rd_vld_in  = 1'b1;
               rd_last_in = (rd_idx_ff + CW'(1)) == count_ff;
            end
            if (rd_vld_ff) begin
               best_in     = nbest;
               best_vld_in = nbest_vld;
               if (rd_last_ff) begin
                  if (nbest_vld) begin
                     dst_wr_en   = 1'b1;
                     dcnt_in     = dcnt_ff + CW'(1);
                     prev_in     = nbest;
                     prev_vld_in = 1'b1;
                     best_vld_in = 1'b0;
                     rd_idx_in   = '0;
                  end else begin
                     state_in = suis_pkg::S_EMIT_RD;
                     emit_in  = '0;
                  end
               end
            end
         end

         // Fetch first distinct value
         suis_pkg::S_EMIT_RD: begin
            dst_rd_en = 1'b1;
            state_in  = suis_pkg::S_EMIT_LD;
         end

         // Load the output register
         suis_pkg::S_EMIT_LD: begin
            rsp_vld_in = 1'b1;
            val_in     = dst_rd_data;
            pos_in     = suis_pkg::POS_W'(emit_ff);
            last_in    = emit_nx == dcnt_ff;
            state_in   = suis_pkg::S_EMIT_WAIT;
         end

         // Hold result until taken; prefetch the next one on acceptance
         suis_pkg::S_EMIT_WAIT: begin
            if (rsp_ch.ready) begin
               rsp_vld_in = 1'b0;
               if (last_ff) begin
                  state_in = suis_pkg::S_LOAD;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  emit_in     = emit_nx;
                  dst_rd_en   = 1'b1;
                  dst_rd_addr = emit_nx[AW-1:0];
                  state_in    = suis_pkg::S_EMIT_LD;
               end
            end
         end

         default: begin
            state_in = suis_pkg::S_LOAD;
         end
      endcase
   end

   // Result channel
   assign rsp_ch.valid          = rsp_vld_ff;
   assign rsp_ch.value_res      = val_ff;
   assign rsp_ch.position       = pos_ff;
   assign rsp_ch.distinct_count = suis_pkg::DCNT_W'(dcnt_ff);
   assign rsp_ch.run_last       = last_ff;
   assign rsp_ch.overflowed     = ovf_ff;

   assign state = state_ff;

endmodule

FILE: hdl/sorted_unique_index_set.sv
// Top level of the sorted unique index set: store, distinct memory, sequencer.
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    value[30:0], set_end
//   rsp_ch   out  valid/ready    value_res[30:0], position[4:0],
//                                distinct_count[5:0], run_last, overflowed
//
// Items are taken one per cycle while a set is loading. After the set_end item
// the sequencer scans the entry store once per distinct value plus one final
// pass, through the single read port of the entry store. Results then leave
// one at a time, each read from the distinct memory and then loaded into the
// output register; the next is read only when the last is taken. req_ch is
// not ready from set_end until the last result is taken. Reset is synchronous
// and clears the sequencer; memory contents are left as they are.
module sorted_unique_index_set #(
   parameter int CAPACITY = suis_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   suis_req_if.sink    req_ch,
   suis_rsp_if.source  rsp_ch
);

   localparam int AW = $clog2(CAPACITY);

   logic                         ent_wr_en;
   logic [AW-1:0]                ent_wr_addr;
   logic [suis_pkg::VALUE_W-1:0] ent_wr_data;
   logic                         ent_rd_en;
   logic [AW-1:0]                ent_rd_addr;
   logic [suis_pkg::VALUE_W-1:0] ent_rd_data;
   logic                         dst_wr_en;
   logic [AW-1:0]                dst_wr_addr;
   logic [suis_pkg::VALUE_W-1:0] dst_wr_data;
   logic                         dst_rd_en;
   logic [AW-1:0]                dst_rd_addr;
   logic [suis_pkg::VALUE_W-1:0] dst_rd_data;
   suis_pkg::state_type          state;

   // Entry store: written while loading, read while scanning
   suis_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (suis_pkg::VALUE_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   // Distinct values in ascending order: written while scanning, read while emitting
   suis_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (suis_pkg::VALUE_W)
   ) u_distinct_ram (
      .clock   (clock),
      .wr_en   (dst_wr_en),
      .wr_addr (dst_wr_addr),
      .wr_data (dst_wr_data),
      .rd_en   (dst_rd_en),
      .rd_addr (dst_rd_addr),
      .rd_data (dst_rd_data)
   );

   suis_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .ent_wr_en   (ent_wr_en),
      .ent_wr_addr (ent_wr_addr),
      .ent_wr_data (ent_wr_data),
      .ent_rd_en   (ent_rd_en),
      .ent_rd_addr (ent_rd_addr),
      .ent_rd_data (ent_rd_data),
      .dst_wr_en   (dst_wr_en),
      .dst_wr_addr (dst_wr_addr),
      .dst_wr_data (dst_wr_data),
      .dst_rd_en   (dst_rd_en),
      .dst_rd_addr (dst_rd_addr),
      .dst_rd_data (dst_rd_data),
      .state       (state)
   );

   // Loading and emitting never overlap
   a_no_load_while_emit: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !rsp_ch.valid)
      else $error("input ready while a result is pending");

   // A set_end item stops loading
   a_set_end_stops: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && req_ch.set_end |=> !req_ch.ready)
      else $error("still loading after set_end");

   // Last result sits at the top position
   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.run_last && (CAPACITY <= 32) |->
         (suis_pkg::DCNT_W'(rsp_ch.position) + suis_pkg::DCNT_W'(1))
            == rsp_ch.distinct_count)
      else $error("last result position does not match distinct count");

   // Taking the last result returns to loading
   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && rsp_ch.run_last |=>
         state == suis_pkg::S_LOAD)
      else $error("sequencer did not return to loading");

endmodule
